>>> rtl/hdrf_pkg.sv
// Shared constants, codes and types for the half-duplex receive FIFO block.
`timescale 1ns / 1ps
package hdrf_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = (PTR_W + 1 > 8) ? PTR_W + 1 : 8;

  localparam int BYTE_W = 8;
  localparam int AVAIL_W = 8;
  localparam int LEN_W = 16;
  localparam int TMO_W = 16;
  localparam int ELAPSED_W = 17;
  localparam int ACT_W = 3;
  localparam int STATUS_W = 2;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

  // Register indexes.
  localparam logic REG_TIMEOUT = 1'b0;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_RX    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEND  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DONE  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd5;

  // Send status codes.
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic                pop_valid;
    logic [AVAIL_W-1:0]  available;
    logic                driving_line;
    logic [STATUS_W-1:0] send_status;
  } result_t;

endpackage

>>> rtl/half_duplex_rx_fifo_with_direction_top.sv
// Top level: APB register, control, ring memory and result registers.
// A result passes through the pending stage (memory read) and then the output registers.
// Throughput: one item per cycle when not stalled; pointers and memory port take one each cycle.
// The next item is taken while a finished result waits, until both result stages are full.
// Reset (synchronous, active high) empties the ring, selects receive, clears the
// transmit timer and sets timeout_ms to 100; memory contents are not cleared.
`timescale 1ns / 1ps
module half_duplex_rx_fifo_with_direction_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hdrf_pkg::ACT_W-1:0]          action,
  input  logic [hdrf_pkg::BYTE_W-1:0]         line_byte,
  input  logic [hdrf_pkg::LEN_W-1:0]          send_length,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hdrf_pkg::BYTE_W-1:0]         popped_byte,
  output logic                                pop_valid,
  output logic [hdrf_pkg::AVAIL_W-1:0]        available,
  output logic                                driving_line,
  output logic [hdrf_pkg::STATUS_W-1:0]       send_status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hdrf_pkg::APB_AW-1:0]         paddr,
  input  logic [hdrf_pkg::APB_DW-1:0]         pwdata,
  output logic [hdrf_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  logic [hdrf_pkg::TMO_W-1:0]  timeout_ms;
  logic                        reg_sel;
  logic                        accept;
  logic                        wr_en, rd_en;
  logic [hdrf_pkg::PTR_W-1:0]  wr_addr, rd_addr;
  logic [hdrf_pkg::BYTE_W-1:0] wr_data, rd_data;
  hdrf_pkg::result_t           result, pend;
  logic                        pend_valid;
  logic                        advance;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == hdrf_pkg::REG_TIMEOUT);
  assign prdata  = reg_sel ? {{(hdrf_pkg::APB_DW - hdrf_pkg::TMO_W){1'b0}}, timeout_ms} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= hdrf_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      timeout_ms <= pwdata[hdrf_pkg::TMO_W-1:0];
    end
  end

  // The pending stage waits for the memory read; it moves on when the output is free.
  assign advance  = pend_valid && (!out_valid || out_ready);
  assign in_ready = !pend_valid || advance;
  assign accept   = in_valid && in_ready;

  hdrf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .line_byte   (line_byte),
    .send_length (send_length),
    .timeout_ms  (timeout_ms),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .result      (result)
  );

  hdrf_ram #(
    .DEPTH (hdrf_pkg::BUFFER_DEPTH),
    .WIDTH (hdrf_pkg::BYTE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      popped_byte  <= pend.pop_valid ? rd_data : '0;
      pop_valid    <= pend.pop_valid;
      available    <= pend.available;
      driving_line <= pend.driving_line;
      send_status  <= pend.send_status;
    end
  end

endmodule

>>> rtl/hdrf_ram.sv
// Single-port-write, registered-read byte memory for the receive ring.
`timescale 1ns / 1ps
module hdrf_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/hdrf_ctrl.sv
// Ring pointers, line direction and transmit timeout control.
`timescale 1ns / 1ps
module hdrf_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [hdrf_pkg::ACT_W-1:0]        action,
  input  logic [hdrf_pkg::BYTE_W-1:0]       line_byte,
  input  logic [hdrf_pkg::LEN_W-1:0]        send_length,
  input  logic [hdrf_pkg::TMO_W-1:0]        timeout_ms,
  output logic                              wr_en,
  output logic [hdrf_pkg::PTR_W-1:0]        wr_addr,
  output logic [hdrf_pkg::BYTE_W-1:0]       wr_data,
  output logic                              rd_en,
  output logic [hdrf_pkg::PTR_W-1:0]        rd_addr,
  output hdrf_pkg::result_t                 result
);

  localparam logic [hdrf_pkg::PTR_W-1:0] LAST = hdrf_pkg::PTR_W'(hdrf_pkg::BUFFER_DEPTH - 1);
  localparam logic [hdrf_pkg::CNT_W-1:0] DEPTH_C = hdrf_pkg::CNT_W'(hdrf_pkg::BUFFER_DEPTH);

  logic [hdrf_pkg::PTR_W-1:0]     write_pointer, write_pointer_next;
  logic [hdrf_pkg::PTR_W-1:0]     read_pointer, read_pointer_next;
  logic                           sending, sending_next;
  logic [hdrf_pkg::ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next, elapsed_inc;
  logic [hdrf_pkg::PTR_W-1:0]     wp_inc, rp_inc;
  logic [hdrf_pkg::CNT_W-1:0]     count;
  logic                           full, empty;
  logic [hdrf_pkg::STATUS_W-1:0]  status;

  assign wp_inc = (write_pointer == LAST) ? '0 : write_pointer + 1'b1;
  assign rp_inc = (read_pointer == LAST) ? '0 : read_pointer + 1'b1;
  assign full   = (wp_inc == read_pointer);
  assign empty  = (write_pointer == read_pointer);
  assign elapsed_inc = (elapsed_ms == hdrf_pkg::ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    sending_next       = sending;
    elapsed_ms_next    = elapsed_ms;
    status             = hdrf_pkg::ST_NONE;
    wr_en              = 1'b0;
    rd_en              = 1'b0;
    case (action)
      hdrf_pkg::ACT_RX: begin
        // Bytes seen while transmitting are our own echo.
        if (!sending && !full) begin
          wr_en              = accept;
          write_pointer_next = wp_inc;
        end
      end
      hdrf_pkg::ACT_POP: begin
        if (!empty) begin
          rd_en             = accept;
          read_pointer_next = rp_inc;
        end
      end
      hdrf_pkg::ACT_FLUSH: begin
        write_pointer_next = '0;
        read_pointer_next  = '0;
      end
      hdrf_pkg::ACT_SEND: begin
        if (send_length == '0 || sending) begin
          status = hdrf_pkg::ST_ERR;
        end else begin
          sending_next    = 1'b1;
          elapsed_ms_next = '0;
        end
      end
      hdrf_pkg::ACT_DONE: begin
        if (sending) begin
          sending_next    = 1'b0;
          elapsed_ms_next = '0;
          status          = hdrf_pkg::ST_OK;
        end
      end
      hdrf_pkg::ACT_TICK: begin
        if (sending) begin
          if (elapsed_inc > {1'b0, timeout_ms}) begin
            sending_next    = 1'b0;
            elapsed_ms_next = '0;
            status          = hdrf_pkg::ST_TIMEOUT;
          end else begin
            elapsed_ms_next = elapsed_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = write_pointer;
  assign wr_data = line_byte;
  assign rd_addr = read_pointer;

  always_comb begin
    if (write_pointer_next >= read_pointer_next) begin
      count = hdrf_pkg::CNT_W'(write_pointer_next) - hdrf_pkg::CNT_W'(read_pointer_next);
    end else begin
      count = DEPTH_C - hdrf_pkg::CNT_W'(read_pointer_next)
              + hdrf_pkg::CNT_W'(write_pointer_next);
    end
  end

  assign result.pop_valid    = rd_en;
  assign result.available    = count[hdrf_pkg::AVAIL_W-1:0];
  assign result.driving_line = sending_next;
  assign result.send_status  = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      sending       <= 1'b0;
      elapsed_ms    <= '0;
    end else if (accept) begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      sending       <= sending_next;
      elapsed_ms    <= elapsed_ms_next;
    end
  end

endmodule

>>> rtl/hdrf_checker.sv
// Port-level checker for the half-duplex receive FIFO, bound to the top level.
`timescale 1ns / 1ps
module hdrf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hdrf_pkg::BYTE_W-1:0]   popped_byte,
  input logic                          pop_valid,
  input logic                          driving_line,
  input logic [hdrf_pkg::STATUS_W-1:0] send_status
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_pop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop_valid |-> popped_byte == '0)
    else $error("popped byte not zero without a valid pop");

  // A finished or timed-out send always leaves the line in receive.
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && (send_status == hdrf_pkg::ST_OK || send_status == hdrf_pkg::ST_TIMEOUT)
    |-> !driving_line)
    else $error("line still driven after send ended");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind half_duplex_rx_fifo_with_direction_top hdrf_checker u_hdrf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .popped_byte  (popped_byte),
  .pop_valid    (pop_valid),
  .driving_line (driving_line),
  .send_status  (send_status)
);

>>> tb/tb.sv
// Self-checking testbench for the half-duplex receive FIFO with direction control.
`timescale 1ns / 1ps
module tb;

  localparam logic [hdrf_pkg::APB_AW-1:0] TIMEOUT_ADDR =
    hdrf_pkg::APB_AW'(4 * hdrf_pkg::REG_TIMEOUT);
  localparam logic [hdrf_pkg::APB_AW-1:0] SPARE_ADDR = hdrf_pkg::APB_AW'(4);
  localparam logic [hdrf_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [hdrf_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd7;
  localparam int IDLE_PCT = 11;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 1000;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [hdrf_pkg::ACT_W-1:0]  action;
    logic [hdrf_pkg::BYTE_W-1:0] line_byte;
    logic [hdrf_pkg::LEN_W-1:0]  send_length;
  } bus_event_t;

  typedef struct {
    logic [hdrf_pkg::BYTE_W-1:0]   popped_byte;
    logic                          pop_valid;
    logic [hdrf_pkg::AVAIL_W-1:0]  available;
    logic                          driving_line;
    logic [hdrf_pkg::STATUS_W-1:0] send_status;
  } ring_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [hdrf_pkg::ACT_W-1:0] action = '0;
  logic [hdrf_pkg::BYTE_W-1:0] line_byte = '0;
  logic [hdrf_pkg::LEN_W-1:0] send_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [hdrf_pkg::BYTE_W-1:0] popped_byte;
  logic pop_valid;
  logic [hdrf_pkg::AVAIL_W-1:0] available;
  logic driving_line;
  logic [hdrf_pkg::STATUS_W-1:0] send_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [hdrf_pkg::APB_AW-1:0] paddr = '0;
  logic [hdrf_pkg::APB_DW-1:0] pwdata = '0;
  logic [hdrf_pkg::APB_DW-1:0] prdata;
  logic pready;

  // Predictor state, at its reset values.
  logic [hdrf_pkg::BYTE_W-1:0] ring_mem [hdrf_pkg::BUFFER_DEPTH];
  int wr_ptr = 0;
  int rd_ptr = 0;
  bit line_busy = 1'b0;
  logic [hdrf_pkg::ELAPSED_W-1:0] elapsed = '0;
  logic [hdrf_pkg::TMO_W-1:0] tmo_limit = hdrf_pkg::TIMEOUT_RESET;

  bus_event_t bus_events[$];
  ring_reply_t ring_replies[$];
  bus_event_t cur_event;
  ring_reply_t want_reply;
  int events_queued = 0;
  int items_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;

  half_duplex_rx_fifo_with_direction_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .line_byte(line_byte), .send_length(send_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_byte(popped_byte), .pop_valid(pop_valid), .available(available),
    .driving_line(driving_line), .send_status(send_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one bus event to the ring and direction state and returns the reply.
  function automatic ring_reply_t step_ring(bus_event_t ev);
    ring_reply_t r;
    int nxt;
    r = '{default: '0};
    case (ev.action)
      hdrf_pkg::ACT_RX: begin
        nxt = (wr_ptr + 1) % hdrf_pkg::BUFFER_DEPTH;
        if (!line_busy && nxt != rd_ptr) begin
          ring_mem[wr_ptr] = ev.line_byte;
          wr_ptr = nxt;
        end
      end
      hdrf_pkg::ACT_POP: begin
        if (wr_ptr != rd_ptr) begin
          r.popped_byte = ring_mem[rd_ptr];
          r.pop_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % hdrf_pkg::BUFFER_DEPTH;
        end
      end
      hdrf_pkg::ACT_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
      end
      hdrf_pkg::ACT_SEND: begin
        if (ev.send_length == '0 || line_busy) begin
          r.send_status = hdrf_pkg::ST_ERR;
        end else begin
          line_busy = 1'b1;
          elapsed = '0;
        end
      end
      hdrf_pkg::ACT_DONE: begin
        if (line_busy) begin
          line_busy = 1'b0;
          elapsed = '0;
          r.send_status = hdrf_pkg::ST_OK;
        end
      end
      hdrf_pkg::ACT_TICK: begin
        if (line_busy) begin
          if (elapsed < hdrf_pkg::ELAPSED_MAX) elapsed = elapsed + 1'b1;
          if (elapsed > {1'b0, tmo_limit}) begin
            line_busy = 1'b0;
            elapsed = '0;
            r.send_status = hdrf_pkg::ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    r.available = hdrf_pkg::AVAIL_W'((wr_ptr - rd_ptr + hdrf_pkg::BUFFER_DEPTH)
                                     % hdrf_pkg::BUFFER_DEPTH);
    r.driving_line = line_busy;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic push_item(input logic [hdrf_pkg::ACT_W-1:0] act,
                           input logic [hdrf_pkg::BYTE_W-1:0] b,
                           input logic [hdrf_pkg::LEN_W-1:0] len);
    bus_events.push_back('{act, b, len});
    if (act <= hdrf_pkg::ACT_TICK) events_queued++;
  endtask

  function automatic logic [hdrf_pkg::BYTE_W-1:0] rand_byte();
    return hdrf_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [hdrf_pkg::LEN_W-1:0] rand_len();
    return hdrf_pkg::LEN_W'($urandom_range(0, 65535));
  endfunction

  // Returns the line to receive, then offers 250 to 300 bytes, up to more than the ring can hold.
  task automatic push_fill();
    int k;
    push_item(hdrf_pkg::ACT_DONE, rand_byte(), rand_len());
    k = $urandom_range(250, 300);
    repeat (k) push_item(hdrf_pkg::ACT_RX, rand_byte(), rand_len());
  endtask

  task automatic add_random_traffic(input int n);
    int goal, pick, k;
    logic [hdrf_pkg::ACT_W-1:0] act;
    logic [hdrf_pkg::LEN_W-1:0] len;
    goal = events_queued + n;
    while (events_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_fill();
      end else if (pick < 6) begin
        k = $urandom_range(50, 280);
        repeat (k) push_item(hdrf_pkg::ACT_POP, rand_byte(), rand_len());
      end else if (pick < 12) begin
        // A whole transmission: start, echoed bytes, ticks, maybe a completion.
        push_item(hdrf_pkg::ACT_SEND, rand_byte(), hdrf_pkg::LEN_W'($urandom_range(1, 65535)));
        k = $urandom_range(0, 3);
        repeat (k) push_item(hdrf_pkg::ACT_RX, rand_byte(), rand_len());
        if ($urandom_range(0, 3) == 0 && tmo_limit <= 200)
          k = int'(tmo_limit) + 1;
        else
          k = $urandom_range(0, (tmo_limit < 20) ? int'(tmo_limit) + 2 : 20);
        repeat (k) push_item(hdrf_pkg::ACT_TICK, rand_byte(), rand_len());
        if ($urandom_range(0, 1)) push_item(hdrf_pkg::ACT_DONE, rand_byte(), rand_len());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) act = hdrf_pkg::ACT_RX;
        else if (pick < 60) act = hdrf_pkg::ACT_POP;
        else if (pick < 63) act = hdrf_pkg::ACT_FLUSH;
        else if (pick < 72) act = hdrf_pkg::ACT_SEND;
        else if (pick < 80) act = hdrf_pkg::ACT_DONE;
        else if (pick < 97) act = hdrf_pkg::ACT_TICK;
        else act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
        len = ($urandom_range(0, 7) == 0) ? '0 : rand_len();
        push_item(act, rand_byte(), len);
      end
    end
  endtask

  task automatic apb_write(input logic [hdrf_pkg::APB_AW-1:0] addr,
                           input logic [hdrf_pkg::APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == TIMEOUT_ADDR) tmo_limit = data[hdrf_pkg::TMO_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [hdrf_pkg::APB_AW-1:0] addr,
                                input logic [hdrf_pkg::TMO_W-1:0] want);
    logic [hdrf_pkg::APB_DW-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("timeout_ms readback", want, got[hdrf_pkg::TMO_W-1:0]);
  endtask

  // Sampled on the falling edge so that the queues and valids have settled.
  task automatic wait_quiet();
    do @(negedge clk); while (bus_events.size() != 0 || in_valid || ring_replies.size() != 0);
  endtask

  // Driver: predicts each transfer as it is accepted, then offers the next event.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ring_replies.push_back(step_ring(cur_event));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (bus_events.size() != 0 &&
            ((items_taken >= 300 && items_taken < 700) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_event = bus_events.pop_front();
          action <= cur_event.action;
          line_byte <= cur_event.line_byte;
          send_length <= cur_event.send_length;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and paces out_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (ring_replies.size() == 0) begin
          $display("%0t: result expected none, got available %0h", $time, available);
          error_count++;
        end else begin
          want_reply = ring_replies.pop_front();
          check_field("popped_byte", want_reply.popped_byte, popped_byte);
          check_field("pop_valid", want_reply.pop_valid, pop_valid);
          check_field("available", want_reply.available, available);
          check_field("driving_line", want_reply.driving_line, driving_line);
          check_field("send_status", want_reply.send_status, send_status);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        // One long back-pressure stretch so the block fills and stalls its input.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 300 && results_seen < 700) ||
                     $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("half_duplex_rx_fifo_with_direction_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_read_check(TIMEOUT_ADDR, hdrf_pkg::TIMEOUT_RESET);

    // Directed opening under the reset timeout.
    push_item(hdrf_pkg::ACT_POP, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_TICK, 8'hFF, 16'hFFFF);
    push_item(hdrf_pkg::ACT_DONE, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_SEND, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_RX, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_RX, 8'hFF, 16'hFFFF);
    push_item(hdrf_pkg::ACT_RX, 8'hA5, 16'h1234);
    push_item(hdrf_pkg::ACT_POP, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_SEND, 8'h00, 16'hFFFF);
    push_item(hdrf_pkg::ACT_SEND, 8'h00, 16'h0001);
    push_item(hdrf_pkg::ACT_RX, 8'h5A, 16'h0000);
    push_item(hdrf_pkg::ACT_TICK, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_DONE, 8'h00, 16'h0000);
    push_item(ACT_SPARE_A, 8'hFF, 16'hFFFF);
    push_item(ACT_SPARE_B, 8'hFF, 16'hFFFF);
    push_item(hdrf_pkg::ACT_RX, 8'h3C, 16'h0000);
    push_item(hdrf_pkg::ACT_FLUSH, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_POP, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_RX, 8'h81, 16'h0000);
    push_item(hdrf_pkg::ACT_POP, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_POP, 8'h00, 16'h0000);
    push_fill();
    add_random_traffic(600);
    wait_quiet();

    // Zero timeout: the first tick of a transmission ends it. Writes to the
    // unused register slot must leave the timeout alone.
    apb_write(TIMEOUT_ADDR, '0);
    apb_write(SPARE_ADDR, $urandom);
    apb_read_check(TIMEOUT_ADDR, '0);
    push_item(hdrf_pkg::ACT_SEND, 8'h00, 16'h0005);
    push_item(hdrf_pkg::ACT_TICK, 8'h00, 16'h0000);
    push_item(hdrf_pkg::ACT_SEND, 8'h00, 16'h8000);
    push_item(hdrf_pkg::ACT_DONE, 8'h00, 16'h0000);
    add_random_traffic(250);
    wait_quiet();

    // Largest timeout: a long transmission stays in transmit and refuses a second start.
    apb_write(TIMEOUT_ADDR, hdrf_pkg::APB_DW'(16'hFFFF));
    apb_read_check(TIMEOUT_ADDR, 16'hFFFF);
    push_item(hdrf_pkg::ACT_SEND, 8'h00, 16'hFFFF);
    push_item(hdrf_pkg::ACT_RX, 8'hC3, 16'h0000);
    repeat (20) push_item(hdrf_pkg::ACT_TICK, rand_byte(), rand_len());
    push_item(hdrf_pkg::ACT_SEND, 8'h00, 16'h0001);
    repeat (10) push_item(hdrf_pkg::ACT_TICK, 8'h00, 16'h0000);
    wait_quiet();

    // Lowering the timeout mid-transmission takes effect on the next tick.
    apb_write(TIMEOUT_ADDR, hdrf_pkg::APB_DW'(3));
    push_item(hdrf_pkg::ACT_TICK, 8'h00, 16'h0000);
    add_random_traffic(300);
    wait_quiet();

    apb_write(TIMEOUT_ADDR, hdrf_pkg::APB_DW'($urandom_range(1, 40)));
    add_random_traffic(250);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (error_count == 0)
      $display("half_duplex_rx_fifo_with_direction_top: match");
    else
      $display("half_duplex_rx_fifo_with_direction_top: mismatch");
    $finish;
  end

endmodule
